### hdl/mcsql_pkg.sv
// Package for the MCS queue lock manager: sizes, opcodes, status codes and
// the controller-to-datapath command struct. No dependencies.
package mcsql_pkg;

  localparam int NumLocks   = 16;
  localparam int NumThreads = 16;

  localparam int OpW      = 2;
  localparam int LockIdxW = 4;
  localparam int ThreadW  = 4;
  localparam int StatusW  = 3;

  localparam int NodeCount = NumLocks * NumThreads;
  localparam int LockAw    = (NumLocks > 1) ? $clog2(NumLocks) : 1;
  localparam int NodeAw    = (NodeCount > 1) ? $clog2(NodeCount) : 1;

  typedef enum logic [OpW-1:0] {
    OpTry     = 2'd0,
    OpAcquire = 2'd1,
    OpRelease = 2'd2,
    OpQuery   = 2'd3
  } opcode_e;

  typedef enum logic [StatusW-1:0] {
    StAcquired = 3'd0,
    StQueued   = 3'd1,
    StBusy     = 3'd2,
    StDone     = 3'd3,
    StMisuse   = 3'd4
  } status_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

### hdl/mcsql_ctrl.sv
// Controller for the MCS queue lock manager: idle/execute sequencing and the
// output valid flag. Depends on mcsql_pkg.
module mcsql_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output mcsql_pkg::cmd_t   cmd_o
);
  import mcsql_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture = in_valid_i && (state_q == StIdle);
    cmd_o.commit  = (state_q == StExec) && (!out_valid_q || out_ready_i);
    state_d       = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.capture) state_d = StExec;
      end
      StExec: begin
        if (cmd_o.commit) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

### hdl/mcsql_dp.sv
// Datapath for the MCS queue lock manager: tail and head pointers, node memory
// (queued flag and successor link), request and result registers. Depends on mcsql_pkg.
module mcsql_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mcsql_pkg::cmd_t                     cmd_i,
  input  logic [mcsql_pkg::OpW-1:0]           opcode_i,
  input  logic [mcsql_pkg::LockIdxW-1:0]      lock_index_i,
  input  logic [mcsql_pkg::ThreadW-1:0]       thread_id_i,
  output logic [mcsql_pkg::StatusW-1:0]       status_o,
  output logic                                lock_free_o,
  output logic                                grant_valid_o,
  output logic [mcsql_pkg::ThreadW-1:0]       grant_thread_o
);
  import mcsql_pkg::*;

  typedef struct packed {
    logic               queued;
    logic               nxt_vld;
    logic [ThreadW-1:0] nxt_id;
  } node_t;

  // holder is the head; a queued thread other than the head is waiting
  logic [NumLocks-1:0]  tail_vld_q;
  logic [ThreadW-1:0]   tail_id_q [NumLocks];
  logic [ThreadW-1:0]   head_id_q [NumLocks];
  node_t                node_mem [NodeCount];
  logic [NodeCount-1:0] node_wr_q;
  node_t                node_rd_q;

  opcode_e              req_op_q;
  logic [LockIdxW-1:0]  req_lk_q;
  logic [ThreadW-1:0]   req_th_q;

  logic [StatusW-1:0]   status_q;
  logic                 lock_free_q;
  logic                 grant_valid_q;
  logic [ThreadW-1:0]   grant_thread_q;

  logic [NodeAw-1:0]    in_node;
  logic                 idx_ok;
  logic [LockAw-1:0]    lidx;
  logic [NodeAw-1:0]    node, pnode;
  logic                 tvld, q_flag, w_flag, svld;
  logic [ThreadW-1:0]   tid, hid;
  logic                 do_take, do_link, do_rel;
  status_e              st;
  logic                 lfree, gv;
  logic [ThreadW-1:0]   gt;

  assign in_node = NodeAw'(32'(lock_index_i) * NumThreads + 32'(thread_id_i));

  always_comb begin
    idx_ok  = (32'(req_lk_q) < NumLocks) && (32'(req_th_q) < NumThreads);
    lidx    = LockAw'(req_lk_q);
    node    = NodeAw'(32'(req_lk_q) * NumThreads + 32'(req_th_q));
    tvld    = tail_vld_q[lidx];
    tid     = tail_id_q[lidx];
    hid     = head_id_q[lidx];
    pnode   = NodeAw'(32'(req_lk_q) * NumThreads + 32'(tid));
    q_flag  = node_rd_q.queued;
    w_flag  = q_flag && (hid != req_th_q);
    svld    = node_rd_q.nxt_vld;
    st      = StMisuse;
    gv      = 1'b0;
    gt      = '0;
    do_take = 1'b0;
    do_rel  = 1'b0;
    if (idx_ok) begin
      unique case (req_op_q)
        OpTry: begin
          if (q_flag) begin
            st = StMisuse;
          end else if (tvld) begin
            st = StBusy;
          end else begin
            st      = StAcquired;
            do_take = 1'b1;
          end
        end
        OpAcquire: begin
          if (q_flag) begin
            st = StMisuse;
          end else begin
            st      = tvld ? StQueued : StAcquired;
            do_take = 1'b1;
          end
        end
        OpRelease: begin
          if (!q_flag || w_flag) begin
            st = StMisuse;
          end else begin
            st     = StDone;
            do_rel = 1'b1;
            gv     = svld;
            gt     = svld ? node_rd_q.nxt_id : '0;
          end
        end
        OpQuery: st = StDone;
        default: st = StMisuse;
      endcase
    end
    // queue empty after the step
    if (!idx_ok) begin
      lfree = 1'b0;
    end else if (do_take) begin
      lfree = 1'b0;
    end else if (do_rel) begin
      lfree = !svld;
    end else begin
      lfree = !tvld;
    end
    do_take = do_take && cmd_i.commit;
    do_rel  = do_rel && cmd_i.commit;
    do_link = do_take && tvld;
  end

  // node_wr_q marks entries written since reset; others read as idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tail_vld_q <= '0;
      node_wr_q  <= '0;
    end else begin
      if (do_take) begin
        tail_vld_q[lidx] <= 1'b1;
        node_wr_q[node]  <= 1'b1;
      end
      if (do_link) node_wr_q[pnode] <= 1'b1;
      if (do_rel && !svld) tail_vld_q[lidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_op_q  <= opcode_e'(opcode_i);
      req_lk_q  <= lock_index_i;
      req_th_q  <= thread_id_i;
      node_rd_q <= node_wr_q[in_node] ? node_mem[in_node] : '0;
    end
    if (do_take) begin
      tail_id_q[lidx] <= req_th_q;
      node_mem[node]  <= {1'b1, 1'b0, {ThreadW{1'b0}}};
      if (!tvld) head_id_q[lidx] <= req_th_q;
    end
    // predecessor is the tail, so it stays queued
    if (do_link) node_mem[pnode] <= {1'b1, 1'b1, req_th_q};
    if (do_rel) begin
      node_mem[node] <= '0;
      if (svld) head_id_q[lidx] <= node_rd_q.nxt_id;
    end
    if (cmd_i.commit) begin
      status_q       <= st;
      lock_free_q    <= lfree;
      grant_valid_q  <= gv;
      grant_thread_q <= gt;
    end
  end

  assign status_o       = status_q;
  assign lock_free_o    = lock_free_q;
  assign grant_valid_o  = grant_valid_q;
  assign grant_thread_o = grant_thread_q;

endmodule

### hdl/mcs_queue_lock_manager.sv
// Top level of the MCS queue lock manager: controller plus datapath.
// Depends on mcsql_pkg, mcsql_ctrl and mcsql_dp.
//
//  channel | handshake              | beat fields
//  --------+------------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o  | opcode_i, lock_index_i, thread_id_i
//  out     | out_valid_o/out_ready_i| status_o, lock_free_o, grant_valid_o,
//          |                        | grant_thread_o
//
// Each request is accepted (node entry read registered), then a read-modify-write of
// the tail, head and node memory loads the result register.
// The result register frees the input side: a new beat is accepted while the
// previous result waits; execution stalls only while that result is untaken.
// Reset clears the tail flags and the per-node written flags; unwritten nodes read idle.
module mcs_queue_lock_manager (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mcsql_pkg::OpW-1:0]         opcode_i,
  input  logic [mcsql_pkg::LockIdxW-1:0]    lock_index_i,
  input  logic [mcsql_pkg::ThreadW-1:0]     thread_id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mcsql_pkg::StatusW-1:0]     status_o,
  output logic                              lock_free_o,
  output logic                              grant_valid_o,
  output logic [mcsql_pkg::ThreadW-1:0]     grant_thread_o
);
  import mcsql_pkg::*;

  cmd_t cmd;

  mcsql_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  mcsql_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (opcode_i),
    .lock_index_i   (lock_index_i),
    .thread_id_i    (thread_id_i),
    .status_o       (status_o),
    .lock_free_o    (lock_free_o),
    .grant_valid_o  (grant_valid_o),
    .grant_thread_o (grant_thread_o)
  );

endmodule

### hdl/mcsql_chk.sv
// Port-level checker for the MCS queue lock manager, bound to the top level.
// Depends on mcsql_pkg.
module mcsql_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [mcsql_pkg::StatusW-1:0]     status_o,
  input logic                              lock_free_o,
  input logic                              grant_valid_o,
  input logic [mcsql_pkg::ThreadW-1:0]     grant_thread_o
);
  import mcsql_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(grant_valid_o) && $stable(grant_thread_o))
    else $error("result beat changed while stalled");

  a_grant_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grant_valid_o |-> status_o == StDone && !lock_free_o)
    else $error("hand-over without a completed release on a held lock");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !grant_valid_o |-> grant_thread_o == '0)
    else $error("grant thread set without a hand-over");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is executing");

endmodule

bind mcs_queue_lock_manager mcsql_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .lock_free_o    (lock_free_o),
  .grant_valid_o  (grant_valid_o),
  .grant_thread_o (grant_thread_o)
);

### tb/tb_mcs_queue_lock_manager.sv
// Self-checking testbench for mcs_queue_lock_manager: directed and random lock requests,
// checked beat by beat against a lock bank predictor held in a small scoreboard class.
// Depends on mcsql_pkg and the mcs_queue_lock_manager RTL.
module tb_mcs_queue_lock_manager;
  import mcsql_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandPerPhase = 275;

  typedef struct packed {
    status_e              status;
    logic                 lock_free;
    logic                 grant_valid;
    logic [ThreadW-1:0]   grant_thread;
  } lock_result_t;

  class lock_scoreboard;
    bit                 tail_valid[NumLocks];
    bit [ThreadW-1:0]   tail_id[NumLocks];
    bit                 link_valid[NodeCount];
    bit [ThreadW-1:0]   link_id[NodeCount];
    bit                 waiting[NodeCount];
    bit                 queued[NodeCount];
    lock_result_t       expected_q[$];
    int                 errors;

    function int holder(int lk);
      for (int t = 0; t < NumThreads; t++) begin
        if (queued[lk*NumThreads + t] && !waiting[lk*NumThreads + t]) return t;
      end
      return -1;
    endfunction

    // Apply one accepted request to the lock bank and queue its result.
    function void note_request(opcode_e op, logic [LockIdxW-1:0] lk,
                               logic [ThreadW-1:0] th);
      lock_result_t r;
      int base;
      int node;
      int other;
      r.status = StMisuse;
      r.lock_free = 1'b0;
      r.grant_valid = 1'b0;
      r.grant_thread = '0;
      if (int'(lk) < NumLocks && int'(th) < NumThreads) begin
        base = int'(lk) * NumThreads;
        node = base + int'(th);
        case (op)
          OpTry: begin
            if (queued[node]) r.status = StMisuse;
            else if (tail_valid[lk]) r.status = StBusy;
            else begin
              link_valid[node] = 1'b0;
              link_id[node] = '0;
              tail_valid[lk] = 1'b1;
              tail_id[lk] = th;
              queued[node] = 1'b1;
              waiting[node] = 1'b0;
              r.status = StAcquired;
            end
          end
          OpAcquire: begin
            if (queued[node]) r.status = StMisuse;
            else begin
              other = base + int'(tail_id[lk]);
              link_valid[node] = 1'b0;
              link_id[node] = '0;
              queued[node] = 1'b1;
              if (!tail_valid[lk]) begin
                waiting[node] = 1'b0;
                r.status = StAcquired;
              end else begin
                waiting[node] = 1'b1;
                link_valid[other] = 1'b1;
                link_id[other] = th;
                r.status = StQueued;
              end
              tail_valid[lk] = 1'b1;
              tail_id[lk] = th;
            end
          end
          OpRelease: begin
            if (!queued[node] || waiting[node]) r.status = StMisuse;
            else begin
              queued[node] = 1'b0;
              if (!link_valid[node]) begin
                tail_valid[lk] = 1'b0;
                tail_id[lk] = '0;
              end else begin
                other = base + int'(link_id[node]);
                waiting[other] = 1'b0;
                r.grant_valid = 1'b1;
                r.grant_thread = link_id[node];
              end
              link_valid[node] = 1'b0;
              link_id[node] = '0;
              r.status = StDone;
            end
          end
          default: r.status = StDone;
        endcase
        r.lock_free = !tail_valid[lk];
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [StatusW-1:0] st, logic lf, logic gv, logic [ThreadW-1:0] gt);
      lock_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result beat status=%0d", st));
        return;
      end
      e = expected_q.pop_front();
      if (st !== e.status)
        report($sformatf("status got %0d want %0d", st, e.status));
      if (lf !== e.lock_free)
        report($sformatf("lock_free got %0b want %0b", lf, e.lock_free));
      if (gv !== e.grant_valid)
        report($sformatf("grant_valid got %0b want %0b", gv, e.grant_valid));
      if (gt !== e.grant_thread)
        report($sformatf("grant_thread got %0d want %0d", gt, e.grant_thread));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OpW-1:0]       opcode_i = '0;
  logic [LockIdxW-1:0]  lock_index_i = '0;
  logic [ThreadW-1:0]   thread_id_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [StatusW-1:0]   status_o;
  logic                 lock_free_o;
  logic                 grant_valid_o;
  logic [ThreadW-1:0]   grant_thread_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;
  lock_scoreboard sb = new();

  mcs_queue_lock_manager uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .lock_index_i   (lock_index_i),
    .thread_id_i    (thread_id_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .lock_free_o    (lock_free_o),
    .grant_valid_o  (grant_valid_o),
    .grant_thread_o (grant_thread_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stall, check every accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(status_o, lock_free_o, grant_valid_o, grant_thread_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task send_req(opcode_e op, logic [LockIdxW-1:0] lk, logic [ThreadW-1:0] th);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    lock_index_i <= lk;
    thread_id_i <= th;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(op, lk, th);
  endtask

  // Mostly a few hot locks so queues get deep; releases mostly by the holder.
  task send_random();
    logic [LockIdxW-1:0] lk;
    logic [ThreadW-1:0] th;
    opcode_e op;
    int pick;
    int hold;
    lk = ($urandom_range(3) != 0) ? LockIdxW'($urandom_range(2)) : LockIdxW'($urandom_range(15));
    th = ThreadW'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 35) op = OpAcquire;
    else if (pick < 70) begin
      op = OpRelease;
      hold = sb.holder(int'(lk));
      if (hold >= 0 && $urandom_range(9) < 8) th = ThreadW'(hold);
    end else if (pick < 85) op = OpTry;
    else op = OpQuery;
    send_req(op, lk, th);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: misuse, busy, hand-over chains, empty release, extreme indexes
    send_req(OpQuery, 4'd0, 4'd0);
    send_req(OpRelease, 4'd0, 4'd0);
    send_req(OpTry, 4'd0, 4'd0);
    send_req(OpTry, 4'd0, 4'd15);
    send_req(OpTry, 4'd0, 4'd0);
    send_req(OpAcquire, 4'd0, 4'd0);
    send_req(OpAcquire, 4'd0, 4'd5);
    send_req(OpAcquire, 4'd0, 4'd15);
    send_req(OpRelease, 4'd0, 4'd5);
    send_req(OpQuery, 4'd0, 4'd9);
    send_req(OpRelease, 4'd0, 4'd0);
    send_req(OpRelease, 4'd0, 4'd5);
    send_req(OpRelease, 4'd0, 4'd15);
    send_req(OpAcquire, 4'd15, 4'd15);
    send_req(OpAcquire, 4'd15, 4'd0);
    send_req(OpRelease, 4'd15, 4'd15);
    send_req(OpAcquire, 4'd15, 4'd15);
    send_req(OpRelease, 4'd15, 4'd0);
    send_req(OpRelease, 4'd15, 4'd15);
    send_req(OpTry, 4'd10, 4'd10);
    send_req(OpAcquire, 4'd5, 4'd10);
    send_req(OpRelease, 4'd10, 4'd10);
    send_req(OpRelease, 4'd5, 4'd10);
    send_req(OpQuery, 4'd15, 4'd15);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (RandPerPhase) send_random();
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### mcs_queue_lock_manager.f
hdl/mcsql_pkg.sv
hdl/mcsql_ctrl.sv
hdl/mcsql_dp.sv
hdl/mcs_queue_lock_manager.sv
hdl/mcsql_chk.sv
tb/tb_mcs_queue_lock_manager.sv
